FILE: design/cfhs_pkg.sv
// package for the coarse/fine homing sequencer: types, widths, codes and reset values
`default_nettype none

package cfhs_pkg;

    // default parameter values
    localparam int ANGLE_WIDTH_DEF = 16;
    localparam int COUNT_WIDTH_DEF = 11;

    // fixed field widths
    localparam int FIELD_W   = 16;
    localparam int SPEED_W   = 7;
    localparam int LIMIT_W   = 15;
    localparam int TICKS_W   = 10;
    localparam int SETPT_W   = 8;
    localparam int PCODE_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 15;

    // stream payload widths, padded to whole bytes
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COARSE_SPEED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FINE_SPEED   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COARSE_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FINE_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_TICKS  = 3'd5;

    // register reset values
    localparam logic [SPEED_W-1:0] RST_COARSE_SPEED = 7'd30;
    localparam logic [SPEED_W-1:0] RST_FINE_SPEED   = 7'd2;
    localparam logic [LIMIT_W-1:0] RST_COARSE_LIMIT = 15'd180;
    localparam logic [LIMIT_W-1:0] RST_FINE_LIMIT   = 15'd10;
    localparam logic [TICKS_W-1:0] RST_SETTLE_TICKS = 10'd500;
    localparam logic [TICKS_W-1:0] RST_CLEAR_TICKS  = 10'd10;

    // reported phase codes
    localparam logic [PCODE_W-1:0] PCODE_COARSE  = 3'd0;
    localparam logic [PCODE_W-1:0] PCODE_SETTLE1 = 3'd1;
    localparam logic [PCODE_W-1:0] PCODE_FINE    = 3'd2;
    localparam logic [PCODE_W-1:0] PCODE_SETTLE2 = 3'd3;
    localparam logic [PCODE_W-1:0] PCODE_DONE    = 3'd4;

    // sequencer phase, one-hot
    typedef enum logic [4:0] {
        PH_COARSE  = 5'b00001,
        PH_SETTLE1 = 5'b00010,
        PH_FINE    = 5'b00100,
        PH_SETTLE2 = 5'b01000,
        PH_DONE    = 5'b10000
    } t_phase;

endpackage

`default_nettype wire

FILE: design/coarse_fine_homing_sequencer_top.sv
// top level of the coarse/fine homing sequencer
`default_nettype none

// homing sequencer for a steered motor, fed one control tick per request
//  - slave stream: one request per millisecond tick carrying the home switch
//    level, the wheel angle and the commanded position
//  - master stream: one result request per tick with loop mode, setpoints,
//    encoder-clear and limit-zero strobes, homed flag and the phase shown
//  - config port: plain write port, register index and data, written while idle
// phases: coarse sweep, settle then clear, fine sweep, settle then clear, done
// home is taken only when the switch reads low on two consecutive ticks
// the result is registered, so it appears in the cycle after the tick is taken
// throughput: one tick per cycle while each result is taken; the whole step is a few
//   compares, small adders and the wait counter between the tick and the result register
// a stalled receiver holds the result register; a new tick is still taken in
//   the cycle the held result leaves, so ready only drops while a result waits
//   and the receiver is not taking it
// reset (synchronous, active low) returns to coarse sweep in the positive
//   direction, restores the register defaults and empties the result register
module coarse_fine_homing_sequencer_top
    import cfhs_pkg::*;
#(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // config write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DAT_W-1:0]  i_cfg_wdata,
    // tick requests
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // tdata from bit 0: home_level[0], angle_deg[16:1], cmd_position[32:17], zero pad
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // result requests
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // tdata from bit 0: position_mode[0], speed_target[8:1], position_target[24:9],
    // encoder_clear[25], limits_zero[26], homed[27], phase[30:28], zero pad[31]
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata
);

    // only the low bits of the angle fields that fit the angle width are used
    localparam int IN_W    = (ANGLE_WIDTH < FIELD_W) ? ANGLE_WIDTH : FIELD_W;
    localparam int CMP_W   = (COUNT_WIDTH > TICKS_W + 1) ? COUNT_WIDTH : TICKS_W + 1;
    localparam int ANG_X_W = FIELD_W + 1;

    // configuration registers
    logic [SPEED_W-1:0] r_coarse_speed;
    logic [SPEED_W-1:0] r_fine_speed;
    logic [LIMIT_W-1:0] r_coarse_limit;
    logic [LIMIT_W-1:0] r_fine_limit;
    logic [TICKS_W-1:0] r_settle_ticks;
    logic [TICKS_W-1:0] r_clear_ticks;

    // sequencer state
    t_phase                   r_phase,      n_phase;
    logic                     r_dir,        n_dir;
    logic                     r_home_prev;
    logic [COUNT_WIDTH-1:0]   r_wait,       n_wait;
    logic [IN_W-1:0]          r_held_pos,   n_held_pos;
    logic [SETPT_W-1:0]       r_held_speed, n_held_speed;

    // result register
    logic                     r_out_valid;
    logic [OUT_DATA_W-1:0]    r_out_data, n_out_data;

    logic                     w_accept;
    logic                     w_level;
    logic [IN_W-1:0]          w_angle_raw;
    logic [IN_W-1:0]          w_cmd_raw;
    logic signed [ANG_X_W-1:0] w_angle;
    logic signed [ANG_X_W-1:0] w_c_lim;
    logic signed [ANG_X_W-1:0] w_f_lim;
    logic                     w_at_home;
    logic                     w_dir_coarse;
    logic                     w_dir_fine;
    logic [COUNT_WIDTH-1:0]   w_wait_cur;
    logic [COUNT_WIDTH-1:0]   w_wait_inc;
    logic [CMP_W-1:0]         w_wait_end;

    logic                     w_pmode;
    logic [SETPT_W-1:0]       w_speed;
    logic [FIELD_W-1:0]       w_pos;
    logic                     w_strobe;
    logic                     w_homed;
    logic [PCODE_W-1:0]       w_pcode;

    // a new tick goes in whenever the result register is free or draining
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_level     = i_s_axis_tdata[0];
    assign w_angle_raw = i_s_axis_tdata[1 +: IN_W];
    assign w_cmd_raw   = i_s_axis_tdata[1 + FIELD_W +: IN_W];
    assign w_angle     = ANG_X_W'($signed(w_angle_raw));
    assign w_c_lim     = $signed({2'b00, r_coarse_limit});
    assign w_f_lim     = $signed({2'b00, r_fine_limit});

    // confirmed home: low now and on the previous tick
    assign w_at_home = !w_level && !r_home_prev;

    // reversal beyond either limit, else keep the current direction
    always_comb begin
        w_dir_coarse = r_dir;
        if (w_angle > w_c_lim) begin
            w_dir_coarse = 1'b1;
        end else if (w_angle < -w_c_lim) begin
            w_dir_coarse = 1'b0;
        end
        w_dir_fine = r_dir;
        if (w_angle > w_f_lim) begin
            w_dir_fine = 1'b1;
        end else if (w_angle < -w_f_lim) begin
            w_dir_fine = 1'b0;
        end
    end

    assign w_wait_end = CMP_W'(r_settle_ticks) + CMP_W'(r_clear_ticks);

    // one tick of the sequence
    always_comb begin
        n_phase      = r_phase;
        n_dir        = r_dir;
        n_wait       = r_wait;
        n_held_pos   = r_held_pos;
        n_held_speed = r_held_speed;
        w_pmode      = 1'b0;
        w_speed      = '0;
        w_pos        = '0;
        w_strobe     = 1'b0;
        w_homed      = 1'b0;
        w_pcode      = PCODE_DONE;

        // capture on home in either sweep; this tick is already a settle tick
        unique case (r_phase) inside
            PH_COARSE: begin
                if (w_at_home) begin
                    n_held_pos = w_angle_raw;
                    n_phase    = PH_SETTLE1;
                    n_wait     = '0;
                end
            end
            PH_FINE: begin
                if (w_at_home) begin
                    n_held_pos = w_angle_raw;
                    n_phase    = PH_SETTLE2;
                    n_wait     = '0;
                end
            end
            PH_SETTLE1, PH_SETTLE2: begin
            end
            default: begin
                // unreachable codes behave as done
                n_phase = PH_DONE;
            end
        endcase

        w_wait_cur = n_wait;
        w_wait_inc = (w_wait_cur == '1) ? w_wait_cur : w_wait_cur + 1'b1;

        unique case (n_phase) inside
            PH_COARSE: begin
                w_pcode      = PCODE_COARSE;
                n_dir        = w_dir_coarse;
                n_held_speed = w_dir_coarse ? SETPT_W'(8'sd0 - $signed({1'b0, r_coarse_speed}))
                                            : {1'b0, r_coarse_speed};
                w_speed      = n_held_speed;
            end
            PH_FINE: begin
                w_pcode = PCODE_FINE;
                // the sweep only moves on while the switch reads high
                if (w_level) begin
                    n_dir        = w_dir_fine;
                    n_held_speed = w_dir_fine ? SETPT_W'(8'sd0 - $signed({1'b0, r_fine_speed}))
                                              : {1'b0, r_fine_speed};
                end
                w_speed = n_held_speed;
            end
            PH_SETTLE1, PH_SETTLE2: begin
                w_pcode = (n_phase == PH_SETTLE1) ? PCODE_SETTLE1 : PCODE_SETTLE2;
                w_pmode = 1'b1;
                if (CMP_W'(w_wait_cur) < CMP_W'(r_settle_ticks)) begin
                    w_pos = FIELD_W'(n_held_pos);
                end else begin
                    w_strobe = 1'b1;
                end
                n_wait = w_wait_inc;
                if (CMP_W'(w_wait_inc) >= w_wait_end) begin
                    n_phase    = (n_phase == PH_SETTLE1) ? PH_FINE : PH_DONE;
                    n_wait     = '0;
                    n_held_pos = '0;
                end
            end
            default: begin
                w_pcode = PCODE_DONE;
                w_pmode = 1'b1;
                w_homed = 1'b1;
                w_pos   = FIELD_W'(w_cmd_raw);
            end
        endcase

        n_out_data = {1'b0, w_pcode, w_homed, w_strobe, w_strobe, w_pos, w_speed, w_pmode};
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coarse_speed <= RST_COARSE_SPEED;
            r_fine_speed   <= RST_FINE_SPEED;
            r_coarse_limit <= RST_COARSE_LIMIT;
            r_fine_limit   <= RST_FINE_LIMIT;
            r_settle_ticks <= RST_SETTLE_TICKS;
            r_clear_ticks  <= RST_CLEAR_TICKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_COARSE_SPEED: r_coarse_speed <= i_cfg_wdata[SPEED_W-1:0];
                REG_FINE_SPEED:   r_fine_speed   <= i_cfg_wdata[SPEED_W-1:0];
                REG_COARSE_LIMIT: r_coarse_limit <= i_cfg_wdata[LIMIT_W-1:0];
                REG_FINE_LIMIT:   r_fine_limit   <= i_cfg_wdata[LIMIT_W-1:0];
                REG_SETTLE_TICKS: r_settle_ticks <= i_cfg_wdata[TICKS_W-1:0];
                REG_CLEAR_TICKS:  r_clear_ticks  <= i_cfg_wdata[TICKS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer state, advanced once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_COARSE;
            r_dir        <= 1'b0;
            r_home_prev  <= 1'b1;
            r_wait       <= '0;
            r_held_pos   <= '0;
            r_held_speed <= '0;
        end else if (w_accept) begin
            r_phase      <= n_phase;
            r_dir        <= n_dir;
            r_home_prev  <= w_level;
            r_wait       <= n_wait;
            r_held_pos   <= n_held_pos;
            r_held_speed <= n_held_speed;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire
